// ----- src/ttw_pkg.sv -----
// Shared constants, types and the sine table for the texture-coordinate warp.
`timescale 1ns / 1ps

package ttw_pkg;

    // Field and register widths
    localparam int COORD_W    = 24;
    localparam int OUT_W      = 28;
    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [OUT_W-1:0]   warp_t;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_TIME = 1'b0,
        REG_WARP_MODE  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_TURBULENT = 1'b0,
        MODE_CAUSTIC   = 1'b1
    } warp_mode_t;

    // Sine table
    localparam int DEF_SINE_TABLE_SIZE = 128;
    localparam int ROM_AW = 7;
    localparam int ROM_SIZE = 1 << ROM_AW;
    localparam int ROM_DW = 8;

    localparam logic [ROM_DW-1:0] SINE_ROM [ROM_SIZE] = '{
        8'd127, 8'd133, 8'd139, 8'd146, 8'd152, 8'd158, 8'd164, 8'd170,
        8'd176, 8'd182, 8'd187, 8'd193, 8'd198, 8'd203, 8'd208, 8'd213,
        8'd217, 8'd221, 8'd226, 8'd229, 8'd233, 8'd236, 8'd239, 8'd242,
        8'd245, 8'd247, 8'd249, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254,
        8'd255, 8'd254, 8'd254, 8'd253, 8'd252, 8'd251, 8'd249, 8'd247,
        8'd245, 8'd242, 8'd239, 8'd236, 8'd233, 8'd229, 8'd226, 8'd221,
        8'd217, 8'd213, 8'd208, 8'd203, 8'd198, 8'd193, 8'd187, 8'd182,
        8'd176, 8'd170, 8'd164, 8'd158, 8'd152, 8'd146, 8'd139, 8'd133,
        8'd127, 8'd121, 8'd115, 8'd108, 8'd102, 8'd96,  8'd90,  8'd84,
        8'd78,  8'd72,  8'd67,  8'd61,  8'd56,  8'd51,  8'd46,  8'd41,
        8'd37,  8'd33,  8'd28,  8'd25,  8'd21,  8'd18,  8'd15,  8'd12,
        8'd9,   8'd7,   8'd5,   8'd3,   8'd2,   8'd1,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd1,   8'd2,   8'd3,   8'd5,   8'd7,
        8'd9,   8'd12,  8'd15,  8'd18,  8'd21,  8'd25,  8'd28,  8'd33,
        8'd37,  8'd41,  8'd46,  8'd51,  8'd56,  8'd61,  8'd67,  8'd72,
        8'd78,  8'd84,  8'd90,  8'd96,  8'd102, 8'd108, 8'd115, 8'd121
    };

    function automatic logic [ROM_DW-1:0] sine_rom_at(input logic [ROM_AW-1:0] addr);
        return SINE_ROM[addr];
    endfunction

    // Phase rates in unsigned Q0.32: 1/(2*pi) and 0.465/(2*pi)
    localparam int RATE_W = 30;
    localparam logic [RATE_W-1:0] INV_TWO_PI_Q32   = 30'd683565276;
    localparam logic [RATE_W-1:0] CAUSTIC_RATE_Q32 = 30'd317857853;

    // Phase and interpolation
    localparam int ARG_W   = 34;
    localparam int SPLIT_W = 17;
    localparam int FRAC_W  = 48;
    localparam int F_W     = 16;
    localparam int LERP_W  = 24;
    localparam logic [F_W:0] ONE_Q16 = 17'd65536;

    // Divide by 255 as multiply by a rounded-up reciprocal
    localparam int DIV255_N  = 29;
    localparam int DIV255_K  = 37;
    localparam int DIV255_MW = 30;
    localparam logic [DIV255_MW-1:0] DIV255_M =
        DIV255_MW'(((64'd1 << DIV255_K) + 64'd254) / 64'd255);
    localparam int Q_W = 21;
    localparam logic [Q_W-1:0] Q_MAX = 21'd1048576;
    localparam logic [LERP_W-1:0] LERP_MAX = 24'd16711680;

    // Sine offset of -8.0 in Q.16, and the sum width
    localparam int SUM_W = 33;
    localparam int SINE_OFFSET = 524288;

endpackage

// ----- src/turbulent_texcoord_warp.sv -----
// Ten-stage pipeline that warps one vertex's texture coordinates per cycle.
// Throughput: one word per cycle; the depth comes from the split phase
// multiply, the table-position multiply and the reciprocal divide by 255.
// An output stall freezes every stage together; nothing is dropped or repeated.
// Reset clears all valid bits, sets frame_time to 0 and selects turbulent mode.
`timescale 1ns / 1ps

module turbulent_texcoord_warp
    import ttw_pkg::*;
#(
    parameter int SINE_TABLE_SIZE = DEF_SINE_TABLE_SIZE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  coord_t                s_coord,
    input  coord_t                t_coord,
    output logic                  out_valid,
    input  logic                  out_stall,
    output warp_t                 s_warped,
    output warp_t                 t_warped,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LANES  = 2;
    localparam int STAGES = 10;
    localparam int OWN_STG = 8;
    localparam int MODE_STG = 9;
    localparam int IDXW   = $clog2(SINE_TABLE_SIZE);
    localparam int POS_W  = FRAC_W + IDXW;
    localparam int LO_W   = SPLIT_W + RATE_W;
    localparam int HI_W   = (ARG_W - SPLIT_W) + RATE_W + 1;
    localparam int HI_KEEP = FRAC_W - SPLIT_W;
    // Table index to ROM address: floor(i * ROM_SIZE / SINE_TABLE_SIZE)
    localparam int ADR_N  = IDXW + ROM_AW;
    localparam int ADR_K  = ADR_N + IDXW;
    localparam int ADR_MW = ADR_K - IDXW + 2;
    localparam int ADR_PW = ADR_N + ADR_MW;
    localparam logic [63:0] ADR_M =
        ((64'd1 << ADR_K) + 64'(SINE_TABLE_SIZE) - 64'd1) / 64'(SINE_TABLE_SIZE);
    localparam int MUL_W  = LERP_W + 1;
    localparam int DIV_PW = DIV255_N + DIV255_MW;
    localparam int RT_W   = SUM_W + 1;
    localparam int CW     = SUM_W + 2;

    // Configuration registers
    logic [TIME_W-1:0] frame_time_reg, frame_time_next;
    warp_mode_t        warp_mode_reg, warp_mode_next;

    // Pipeline control
    logic               adv;
    logic [STAGES-1:0]  v_reg, v_next;

    // Stage payload
    coord_t                    own_reg [OWN_STG][LANES];
    coord_t                    own_next [OWN_STG][LANES];
    warp_mode_t                mode_reg [MODE_STG];
    warp_mode_t                mode_next [MODE_STG];
    logic signed [ARG_W-1:0]   a1_reg [LANES], a1_next [LANES];
    logic [LO_W-1:0]           lo2_reg [LANES], lo2_next [LANES];
    logic [HI_KEEP-1:0]        hi2_reg [LANES], hi2_next [LANES];
    logic [FRAC_W-1:0]         frac3_reg [LANES], frac3_next [LANES];
    logic [IDXW-1:0]           i4_reg [LANES], i4_next [LANES];
    logic [F_W-1:0]            f4_reg [LANES], f4_next [LANES];
    logic [ROM_AW-1:0]         ad0_reg [LANES], ad0_next [LANES];
    logic [ROM_AW-1:0]         ad1_reg [LANES], ad1_next [LANES];
    logic [F_W-1:0]            f5_reg [LANES];
    logic [ROM_DW-1:0]         r0_reg [LANES], r0_next [LANES];
    logic [ROM_DW-1:0]         r1_reg [LANES], r1_next [LANES];
    logic [F_W-1:0]            f6_reg [LANES];
    logic [LERP_W-1:0]         lerp7_reg [LANES], lerp7_next [LANES];
    logic [Q_W-1:0]            q8_reg [LANES], q8_next [LANES];
    logic signed [SUM_W-1:0]   sum9_reg [LANES], sum9_next [LANES];
    warp_t                     wout_reg [LANES], wout_next [LANES];

    // Combinational intermediates
    coord_t                    own_in [LANES];
    coord_t                    other_in [LANES];
    logic signed [ARG_W-1:0]   other_ext [LANES];
    logic [ARG_W-1:0]          time_ext;
    logic [RATE_W-1:0]         rate;
    logic signed [HI_W-1:0]    hi_full [LANES];
    logic [POS_W-1:0]          pos_full [LANES];
    logic [IDXW-1:0]           i_next [LANES];
    logic [ADR_PW-1:0]         ap0 [LANES];
    logic [ADR_PW-1:0]         ap1 [LANES];
    logic [F_W:0]              wgt0 [LANES];
    logic [DIV255_N-1:0]       dnum [LANES];
    logic [DIV_PW-1:0]         dprod [LANES];
    logic signed [RT_W-1:0]    trb [LANES];
    logic signed [CW-1:0]      c3 [LANES];
    logic signed [CW-1:0]      cst [LANES];

    // Move the whole pipeline unless the output word is held
    assign adv       = !(v_reg[STAGES-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = v_reg[STAGES-1];
    assign s_warped  = wout_reg[0];
    assign t_warped  = wout_reg[1];

    // Decode configuration writes
    always_comb
    begin
        frame_time_next = frame_time_reg;
        warp_mode_next  = warp_mode_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_TIME: frame_time_next = cfg_data[TIME_W-1:0];
                REG_WARP_MODE:  warp_mode_next  = warp_mode_t'(cfg_data[0]);
                default:        frame_time_next = frame_time_reg;
            endcase
        end
    end

    // Advance valid bits
    always_comb
    begin
        v_next = {v_reg[STAGES-2:0], in_valid};
    end

    // Stage datapath
    always_comb
    begin
        own_in[0]   = s_coord;
        other_in[0] = t_coord;
        own_in[1]   = t_coord;
        other_in[1] = s_coord;
        time_ext    = {{(ARG_W-TIME_W){1'b0}}, frame_time_reg};
        rate        = (mode_reg[0] == MODE_TURBULENT) ? INV_TWO_PI_Q32 : CAUSTIC_RATE_Q32;

        // Carry coordinate and mode along
        mode_next[0] = warp_mode_reg;
        for (int k = 1; k < MODE_STG; k++)
        begin
            mode_next[k] = mode_reg[k-1];
        end

        for (int l = 0; l < LANES; l++)
        begin
            own_next[0][l] = own_in[l];
            for (int k = 1; k < OWN_STG; k++)
            begin
                own_next[k][l] = own_reg[k-1][l];
            end

            // Stage 1: phase argument in Q.16 radians
            other_ext[l] = ARG_W'(other_in[l]);
            if (warp_mode_reg == MODE_TURBULENT)
            begin
                a1_next[l] = (other_ext[l] <<< 9) + $signed(time_ext);
            end
            else
            begin
                a1_next[l] = (other_ext[l] <<< 8) + $signed(time_ext);
            end

            // Stage 2: partial products of argument times rate
            lo2_next[l] = LO_W'(a1_reg[l][SPLIT_W-1:0]) * LO_W'(rate);
            hi_full[l]  = $signed(a1_reg[l][ARG_W-1:SPLIT_W]) * $signed({1'b0, rate});
            hi2_next[l] = hi_full[l][HI_KEEP-1:0];

            // Stage 3: fractional turn, wrapping at one turn
            frac3_next[l] = FRAC_W'(lo2_reg[l]) + {hi2_reg[l], {SPLIT_W{1'b0}}};

            // Stage 4: table position, entry and lerp weight
            pos_full[l] = POS_W'(frac3_reg[l]) * POS_W'(SINE_TABLE_SIZE);
            i4_next[l]  = pos_full[l][FRAC_W +: IDXW];
            f4_next[l]  = pos_full[l][FRAC_W-1 -: F_W];

            // Stage 5: map both neighbor entries to ROM addresses
            i_next[l] = (i4_reg[l] == IDXW'(SINE_TABLE_SIZE - 1)) ? '0 : i4_reg[l] + 1'b1;
            ap0[l] = ADR_PW'({i4_reg[l], {ROM_AW{1'b0}}}) * ADR_PW'(ADR_M[ADR_MW-1:0]);
            ap1[l] = ADR_PW'({i_next[l], {ROM_AW{1'b0}}}) * ADR_PW'(ADR_M[ADR_MW-1:0]);
            ad0_next[l] = ap0[l][ADR_K +: ROM_AW];
            ad1_next[l] = ap1[l][ADR_K +: ROM_AW];

            // Stage 6: read the sine table
            r0_next[l] = sine_rom_at(ad0_reg[l]);
            r1_next[l] = sine_rom_at(ad1_reg[l]);

            // Stage 7: linear interpolation
            wgt0[l] = ONE_Q16 - {1'b0, f6_reg[l]};
            lerp7_next[l] = LERP_W'(MUL_W'(r0_reg[l]) * MUL_W'(wgt0[l])
                                  + MUL_W'(r1_reg[l]) * MUL_W'(f6_reg[l]));

            // Stage 8: round(16 * lerp / 255) by reciprocal
            dnum[l]  = DIV255_N'({lerp7_reg[l], 4'b0000}) + DIV255_N'(127);
            dprod[l] = DIV_PW'(dnum[l]) * DIV_PW'(DIV255_M);
            q8_next[l] = dprod[l][DIV255_K +: Q_W];

            // Stage 9: coordinate in Q.16 plus sine
            sum9_next[l] = (SUM_W'(own_reg[OWN_STG-1][l]) <<< 8)
                         + $signed(SUM_W'(q8_reg[l]))
                         - SUM_W'(SINE_OFFSET);

            // Stage 10: scale and round, ties toward +infinity
            trb[l] = (RT_W'(sum9_reg[l]) + RT_W'(32)) >>> 6;
            c3[l]  = (CW'(sum9_reg[l]) <<< 1) + CW'(sum9_reg[l]);
            cst[l] = (CW'(64) - c3[l]) >>> 7;
            if (mode_reg[MODE_STG-1] == MODE_TURBULENT)
            begin
                wout_next[l] = trb[l][OUT_W-1:0];
            end
            else
            begin
                wout_next[l] = cst[l][OUT_W-1:0];
            end
        end
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= '0;
            frame_time_reg <= '0;
            warp_mode_reg  <= MODE_TURBULENT;
        end
        else
        begin
            frame_time_reg <= frame_time_next;
            warp_mode_reg  <= warp_mode_next;
            if (adv)
            begin
                v_reg <= v_next;
            end
        end
    end

    // Advance stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            own_reg  <= own_next;
            mode_reg <= mode_next;
            for (int l = 0; l < LANES; l++)
            begin
                a1_reg[l]    <= a1_next[l];
                lo2_reg[l]   <= lo2_next[l];
                hi2_reg[l]   <= hi2_next[l];
                frac3_reg[l] <= frac3_next[l];
                i4_reg[l]    <= i4_next[l];
                f4_reg[l]    <= f4_next[l];
                ad0_reg[l]   <= ad0_next[l];
                ad1_reg[l]   <= ad1_next[l];
                f5_reg[l]    <= f4_reg[l];
                r0_reg[l]    <= r0_next[l];
                r1_reg[l]    <= r1_next[l];
                f6_reg[l]    <= f5_reg[l];
                lerp7_reg[l] <= lerp7_next[l];
                q8_reg[l]    <= q8_next[l];
                sum9_reg[l]  <= sum9_next[l];
                wout_reg[l]  <= wout_next[l];
            end
        end
    end

    // A held output word freezes every valid bit
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(v_reg))
        else $error("pipeline moved while output word was held");

    // Table entry stays inside the table
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] |-> (i4_reg[0] <= IDXW'(SINE_TABLE_SIZE - 1)
                      && i4_reg[1] <= IDXW'(SINE_TABLE_SIZE - 1)))
        else $error("table entry out of range");

    // Interpolated value never exceeds the peak entry
    a_lerp_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[6] |-> (lerp7_reg[0] <= LERP_MAX && lerp7_reg[1] <= LERP_MAX))
        else $error("interpolation out of range");

    // Reciprocal divide stays within the scaled sine span
    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[7] |-> (q8_reg[0] <= Q_MAX && q8_reg[1] <= Q_MAX))
        else $error("divide by 255 out of range");

endmodule

// ----- tb/sv/turbulent_texcoord_warp_tb.sv -----
// Self-checking testbench for the turbulent texture-coordinate warp pipeline.
`timescale 1ns / 1ps

module turbulent_texcoord_warp_tb;
    import ttw_pkg::*;

    localparam int      TABLE_ENTRIES = DEF_SINE_TABLE_SIZE;
    localparam int      PIPE_LATENCY  = 10;
    localparam longint  RUN_LIMIT_NS  = 64'd10_000_000;

    // Phase rates in Q0.32 turns per radian: 1/(2*pi) and 0.465/(2*pi)
    localparam longint unsigned TURB_RATE      = 64'd683565276;
    localparam longint unsigned CAUS_RATE      = 64'd317857853;
    localparam longint unsigned TURN_FRAC_MASK = 64'hFFFF_FFFF_FFFF;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        warp_t s;
        warp_t t;
    } warp_pair_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    coord_t     s_coord   = '0;
    coord_t     t_coord   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    warp_t      s_warped;
    warp_t      t_warped;
    logic       cfg_wr_en = 1'b0;
    cfg_reg_t   cfg_index = REG_FRAME_TIME;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copy as the block holds it
    logic [TIME_W-1:0] cur_time = '0;
    warp_mode_t        cur_mode = MODE_TURBULENT;

    warp_pair_t warp_expect_q[$];
    int         mismatches = 0;
    logic       idling_on  = 1'b1;

    turbulent_texcoord_warp uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .s_coord   (s_coord),
        .t_coord   (t_coord),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .s_warped  (s_warped),
        .t_warped  (t_warped),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Map a table entry onto the 128-entry ROM
    function automatic longint unsigned table_entry(int unsigned idx);
        return longint'(SINE_ROM[(idx * ROM_SIZE / TABLE_ENTRIES) % ROM_SIZE]);
    endfunction

    // Interpolated sine in Q.16, range -8..+8, of a Q.16 radian phase
    function automatic longint sine_q16(longint phase, longint unsigned rate);
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned pos;
        longint unsigned f;
        longint unsigned lerp;
        int unsigned     i0;
        int unsigned     i1;
        mag  = (phase < 0) ? -phase : phase;
        prod = mag * rate;
        if (phase < 0)
            prod = -prod;
        pos  = (prod & TURN_FRAC_MASK) * TABLE_ENTRIES;
        i0   = (pos >> 48) % TABLE_ENTRIES;
        i1   = (i0 + 1) % TABLE_ENTRIES;
        f    = (pos >> 32) & 64'hFFFF;
        lerp = table_entry(i0) * (64'd65536 - f) + table_entry(i1) * f;
        return longint'((64'd16 * lerp + 64'd127) / 64'd255) - SINE_OFFSET;
    endfunction

    // Warp one coordinate by the sine of the other; round half up
    function automatic warp_t warp_coord(coord_t own, coord_t other,
                                         logic [TIME_W-1:0] ftime, warp_mode_t mode);
        longint sum;
        if (mode == MODE_TURBULENT)
        begin
            sum = longint'(own) * 256
                + sine_q16(longint'(other) * 512 + longint'(ftime), TURB_RATE);
            return warp_t'((sum + 32) >>> 6);
        end
        sum = longint'(own) * 256
            + sine_q16(longint'(ftime) + longint'(other) * 256, CAUS_RATE);
        return warp_t'((-3 * sum + 64) >>> 7);
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2, 3, 4: return coord_t'(int'($urandom_range(0, 16383)) - 8192);
            default: return coord_t'($urandom());
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_frame_time();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom();
        endcase
    endfunction

    // Write one register; the block must be idle
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_FRAME_TIME: cur_time = data[TIME_W-1:0];
            REG_WARP_MODE:  cur_mode = warp_mode_t'(data[0]);
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one vertex word, hold it until accepted, then log its expected result
    task automatic send_vertex(input coord_t s, input coord_t t);
        warp_pair_t want;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        s_coord  <= s;
        t_coord  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want.s = warp_coord(s, t, cur_time, cur_mode);
        want.t = warp_coord(t, s, cur_time, cur_mode);
        warp_expect_q.push_back(want);
    endtask

    // Hold off input until every outstanding word has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (warp_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_extremes();
        send_vertex(COORD_MAX, COORD_MAX);
        send_vertex(COORD_MIN, COORD_MIN);
        send_vertex(COORD_MAX, COORD_MIN);
        send_vertex(COORD_MIN, COORD_MAX);
        send_vertex('0, '0);
    endtask

    // Registers as left by reset: time zero, turbulent mode
    task automatic test_reset_defaults();
        send_vertex('0, '0);
        send_vertex(coord_t'(256), coord_t'(-256));
        send_vertex(coord_t'(-1), coord_t'(1));
        wait_for_drain();
    endtask

    // Turbulent mode at the time extremes; junk above the mode bit is ignored
    task automatic test_turbulent_extremes();
        write_reg(REG_WARP_MODE, {31'h7FFF_FFFF, MODE_TURBULENT});
        write_reg(REG_FRAME_TIME, '1);
        send_extremes();
        wait_for_drain();
        // phase just below a full turn: interpolation wraps from last entry to first
        write_reg(REG_FRAME_TIME, '0);
        send_vertex('0, coord_t'(-1));
        send_vertex(coord_t'(-1), coord_t'(-1));
        wait_for_drain();
    endtask

    task automatic test_caustic_extremes();
        write_reg(REG_WARP_MODE, {31'h5555_5555, MODE_CAUSTIC});
        send_extremes();
        wait_for_drain();
        write_reg(REG_FRAME_TIME, '1);
        send_extremes();
        wait_for_drain();
    endtask

    // Random vertices under a fresh random frame time per phase, alternating turbulent and caustic modes
    task automatic test_random_phases(input int phases, input int per_phase);
        warp_mode_t mode;
        for (int p = 0; p < phases; p++)
        begin
            mode = (p % 2 == 0) ? MODE_TURBULENT : MODE_CAUSTIC;
            write_reg(REG_FRAME_TIME, pick_frame_time());
            write_reg(REG_WARP_MODE, {31'($urandom()), mode});
            for (int n = 0; n < per_phase; n++)
                send_vertex(pick_coord(), pick_coord());
            wait_for_drain();
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_quiet_tail(input int count);
        idling_on = 1'b0;
        write_reg(REG_FRAME_TIME, $urandom());
        write_reg(REG_WARP_MODE, {31'($urandom()), MODE_CAUSTIC});
        for (int n = 0; n < count; n++)
            send_vertex(pick_coord(), pick_coord());
        wait_for_drain();
    endtask

    // Output stall in random bursts
    initial
    begin : out_stall_gen
        forever
        begin
            @(posedge clk);
            if (idling_on && rst_n && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted output word with the oldest expectation
    always @(posedge clk)
    begin : check_words
        warp_pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (warp_expect_q.size() == 0)
            begin
                $display("%0t: unexpected word s_warped=%0d t_warped=%0d",
                         $time, s_warped, t_warped);
                mismatches++;
            end
            else
            begin
                want = warp_expect_q.pop_front();
                if (s_warped !== want.s)
                begin
                    $display("%0t: s_warped expected %0d got %0d", $time, want.s, s_warped);
                    mismatches++;
                end
                if (t_warped !== want.t)
                begin
                    $display("%0t: t_warped expected %0d got %0d", $time, want.t, t_warped);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : run_tests
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_turbulent_extremes();
        test_caustic_extremes();
        test_random_phases(6, 200);
        test_quiet_tail(250);
        repeat (PIPE_LATENCY + 5) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
